### sv/fpfa_pkg.sv
// Shared types and constants for the fixed-partition fit allocator.
package fpfa_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic REG_FIT_POLICY  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [3:0]           block_index;
    logic [SIZE_BITS-1:0] size_value;
  } item_t;

  typedef struct packed {
    logic                 granted;
    logic [3:0]           chosen_block;
    logic [SIZE_BITS-1:0] leftover_space;
  } result_t;

endpackage

### sv/fixed_partition_fit_allocator_core.sv
// Top level of the fixed-partition fit allocator: register port, scan sequencer, result register.

// The block keeps up to sixteen partitions, each with a size and a busy flag, and takes one item
// at a time. A load, a clear or an unused mode passes through the result step before its
// all-zero result beat is in the result register. An allocation request takes the item, then
// the single size comparator examines at most limit partitions one at a time, where limit is
// block_count clamped to sixteen, then a closing step, and last the result is formed and
// the winner marked busy. First fit stops at the first free partition large enough. A new item is
// taken as soon as the previous one sits in the result register, even if that beat is stalled.
// Sizes of partitions that were never loaded are unknown, so a request must not reach them.
module fixed_partition_fit_allocator_core import fpfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result
);

  logic [1:0]           fit_policy;
  logic [4:0]           block_count;

  state_t               state;
  state_t               state_next;

  logic [SIZE_BITS-1:0] part_size [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] busy;

  logic [CNT_W-1:0]     scan_cnt;
  logic [CNT_W-1:0]     scan_lim;
  logic [SIZE_BITS-1:0] req_size;
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [SIZE_BITS-1:0] pick_size;

  logic                 cfg_wr;
  logic                 item_acc;
  logic                 scan_done;
  logic [IDX_W-1:0]     scan_idx;
  logic [SIZE_BITS-1:0] cur_size;
  logic                 fits;
  logic                 better;
  logic                 take;
  logic                 first_mode;
  logic                 res_load;
  logic [CNT_W-1:0]     lim_next;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= POL_FIRST;
      block_count <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FIT_POLICY:  fit_policy  <= pwdata[1:0];
        REG_BLOCK_COUNT: block_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_FIT_POLICY:  prdata = {{(PDATA_W-2){1'b0}}, fit_policy};
      REG_BLOCK_COUNT: prdata = {{(PDATA_W-5){1'b0}}, block_count};
      default: prdata = '0;
    endcase
  end

  // Item handshake.
  assign item_stall = (state != ST_IDLE);
  assign item_acc   = item_valid && !item_stall;

  assign lim_next = (block_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                        : CNT_W'(block_count);

  // Shared compare unit: one partition per cycle against the request and the current pick.
  assign scan_done  = (scan_cnt == scan_lim);
  assign scan_idx   = scan_cnt[IDX_W-1:0];
  assign cur_size   = part_size[scan_idx];
  assign fits       = !busy[scan_idx] && (cur_size >= req_size);
  assign first_mode = (fit_policy != POL_BEST) && (fit_policy != POL_WORST);
  assign better     = (fit_policy == POL_BEST) ? (cur_size <= pick_size)
                                               : (cur_size >= pick_size);
  assign take       = fits && (first_mode || !found || better);

  assign res_load = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_acc) begin
          state_next = (item.mode == MODE_ALLOC) ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (scan_done || (take && first_mode)) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Partition table and scan registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= '0;
      found <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_acc) begin
            found <= 1'b0;
            if (item.mode == MODE_LOAD) begin
              busy[item.block_index[IDX_W-1:0]] <= 1'b0;
            end else if (item.mode == MODE_CLEAR) begin
              busy <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (!scan_done && take) begin
            found <= 1'b1;
          end
        end
        ST_RESULT: begin
          if (res_load && found) begin
            busy[pick] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_acc) begin
      scan_cnt <= '0;
      scan_lim <= lim_next;
      req_size <= item.size_value;
      if (item.mode == MODE_LOAD) begin
        part_size[item.block_index[IDX_W-1:0]] <= item.size_value;
      end
    end else if (state == ST_SCAN && !scan_done) begin
      scan_cnt <= scan_cnt + CNT_W'(1);
      if (take) begin
        pick      <= scan_idx;
        pick_size <= cur_size;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_RESULT && res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && res_load) begin
      result.granted <= found;
      if (found) begin
        result.chosen_block   <= 4'(pick);
        result.leftover_space <= pick_size - req_size;
      end else begin
        result.chosen_block   <= '0;
        result.leftover_space <= '0;
      end
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan_cnt <= scan_lim)
    else $error("scan counter ran past the partition limit");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && found) |-> ({1'b0, pick} < scan_lim))
    else $error("picked partition lies beyond the limit");

  a_pick_fits: assert property (@(posedge clk) disable iff (rst)
    found |-> pick_size >= req_size)
    else $error("picked partition is smaller than the request");

  a_grant_marks_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && res_load && found) |=> busy[$past(pick)])
    else $error("granted partition was not marked busy");

  a_result_frees_seq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && res_load) |=> (state == ST_IDLE && result_valid))
    else $error("result beat not loaded on leaving the result step");

endmodule
